>>> rtl/core/fss_pkg.sv
// shared types, constants and character-class functions of the fuzzy subsequence scorer
`default_nettype none

package fss_pkg;

	// default query capacity
	localparam int QUERY_MAX_DEF = 32;

	// character code and item commands
	typedef logic [15:0] char_t;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_CHAR   = 2'd2,
		CMD_END    = 2'd3
	} cmd_e;

	// scoring constants
	localparam logic [3:0] PTS_MATCH      = 4'd1;
	localparam logic [3:0] BONUS_CONSEC   = 4'd5;
	localparam logic [3:0] BONUS_BOUNDARY = 4'd8;
	localparam logic [3:0] BONUS_CASE     = 4'd1;
	localparam int         BONUS_NAME     = 3;
	localparam logic [4:0] LEN_TENS_CAP   = 5'd20;
	localparam logic [3:0] LEN_ONES_LAST  = 4'd9;
	localparam int         SCORE_CEIL     = 1023;
	localparam char_t      CHAR_SLASH     = 16'h002F;
	localparam char_t      CHAR_BSLASH    = 16'h005C;
	localparam char_t      CHAR_ANGLE     = 16'h203A;

	// whitespace that is never stored in the query
	function automatic logic is_space(input char_t c);
		return (c >= 16'h0009 && c <= 16'h000D) || c == 16'h0020 || c == 16'h0085 ||
			c == 16'h00A0 || c == 16'h1680 || (c >= 16'h2000 && c <= 16'h200A) ||
			c == 16'h2028 || c == 16'h2029 || c == 16'h202F || c == 16'h205F ||
			c == 16'h3000;
	endfunction

	function automatic logic is_lower(input char_t c);
		return c >= 16'h0061 && c <= 16'h007A;
	endfunction

	function automatic logic is_upper(input char_t c);
		return c >= 16'h0041 && c <= 16'h005A;
	endfunction

	// ascii-only case fold to lower
	function automatic char_t fold(input char_t c);
		return is_upper(c) ? c + 16'h0020 : c;
	endfunction

	function automatic logic is_slash(input char_t c);
		return c == CHAR_SLASH || c == CHAR_BSLASH;
	endfunction

	// word separators
	function automatic logic is_sep(input char_t c);
		return is_slash(c) || c == 16'h005F || c == 16'h002D || c == 16'h002E ||
			c == 16'h0020 || c == 16'h003A || c == CHAR_ANGLE;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/fss_in_if.sv
// input channel: command and character code with valid/ready
`default_nettype none

interface fss_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [15:0] char_code;

	modport source(output valid, output command, output char_code, input ready);
	modport sink(input valid, input command, input char_code, output ready);
endinterface

`default_nettype wire

>>> rtl/core/fss_out_if.sv
// result channel: score and overflow flag with valid/ready
`default_nettype none

interface fss_out_if;
	logic               valid;
	logic               ready;
	logic signed [10:0] score;
	logic               query_overflow;

	modport source(output valid, output score, output query_overflow, input ready);
	modport sink(input valid, input score, input query_overflow, output ready);
endinterface

`default_nettype wire

>>> rtl/core/fss_ram.sv
// generic single-port-write, registered-read RAM (read returns old data on collision)
`default_nettype none

module fss_ram #(
	parameter  int WIDTH = 16,
	parameter  int DEPTH = 32,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                       clk,
	input  wire logic                       we,
	input  wire logic [AW-1:0]              waddr,
	input  wire logic [WIDTH-1:0]           wdata,
	input  wire logic [AW-1:0]              raddr,
	output      logic [WIDTH-1:0]           rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule

`default_nettype wire

>>> rtl/core/fuzzy_subsequence_scorer.sv
// Fuzzy subsequence scorer: loads a query (whitespace skipped, excess flagged), then scores
// streamed candidate characters by greedy case-insensitive subsequence match. Every item
// enters the input register and is worked by one level of compare and bonus logic against
// the state registers; an end-of-candidate item lands its result in the output register,
// and items are accepted back to back every cycle, also while the output register holds a
// result not yet taken, unless an end item waits on it. The query lives in a registered-read
// RAM that is read ahead at the next match position, with a bypass for a character written
// to that same position; its entries are never cleared, only entries below the query length
// are ever used. Only an end item waiting on a full output register stalls the input.
`default_nettype none

module fuzzy_subsequence_scorer import fss_pkg::*; #(
	parameter int QUERY_MAX = QUERY_MAX_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	fss_in_if.sink   cand,
	fss_out_if.source result
);
	localparam int LW  = $clog2(QUERY_MAX + 1);
	localparam int AW  = (QUERY_MAX > 1) ? $clog2(QUERY_MAX) : 1;
	localparam int BW  = $clog2(QUERY_MAX * 15 + 1);
	localparam int TW0 = $clog2(QUERY_MAX * 18 + 1);
	localparam int TW  = (TW0 > 10) ? TW0 : 10;

	// input register
	logic  valid_s1;
	cmd_e  cmd_s1;
	char_t char_s1;

	// match state
	logic [LW-1:0] len_q, len_d;
	logic [LW-1:0] ptr_q, ptr_d;
	logic          ovf_q, ovf_d;
	logic          bound_q, bound_d;
	logic          prev_lower_q, prev_lower_d;
	logic          prev_hit_q, prev_hit_d;
	logic [BW-1:0] base_q, base_d;
	logic [LW-1:0] name_q, name_d;
	logic [3:0]    ones_q, ones_d;
	logic [4:0]    tens_q, tens_d;

	// store access and bypass
	logic  wr_en;
	char_t ram_rdata;
	logic  byp_q;
	char_t byp_data_q;
	char_t q_char;

	// result register
	logic               res_valid_q;
	logic signed [10:0] res_score_q;
	logic               res_ovf_q;

	logic               advance_s1;
	logic               hit;
	logic               boundary;
	logic [3:0]         pts;
	logic [TW-1:0]      total;
	logic [TW-1:0]      pen;
	logic [TW-1:0]      net;
	logic [9:0]         clamped;
	logic signed [10:0] score_d;

	// handshake
	assign advance_s1  = valid_s1 && (cmd_s1 != CMD_END || !res_valid_q || result.ready);
	assign cand.ready  = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cand.ready) begin
			valid_s1 <= cand.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cand.valid && cand.ready) begin
			cmd_s1  <= cmd_e'(cand.command);
			char_s1 <= cand.char_code;
		end
	end

	// match compare and points
	assign q_char   = byp_q ? byp_data_q : ram_rdata;
	assign hit      = (ptr_q < len_q) && (fold(char_s1) == fold(q_char));
	assign boundary = bound_q || (prev_lower_q && is_upper(char_s1));
	assign pts      = PTS_MATCH + (prev_hit_q ? BONUS_CONSEC : 4'd0)
		+ (boundary ? BONUS_BOUNDARY : 4'd0) + ((char_s1 == q_char) ? BONUS_CASE : 4'd0);

	// next state
	always_comb begin
		len_d        = len_q;
		ptr_d        = ptr_q;
		ovf_d        = ovf_q;
		bound_d      = bound_q;
		prev_lower_d = prev_lower_q;
		prev_hit_d   = prev_hit_q;
		base_d       = base_q;
		name_d       = name_q;
		ones_d       = ones_q;
		tens_d       = tens_q;
		wr_en        = 1'b0;
		if (advance_s1) begin
			unique case (cmd_s1)
				CMD_CLEAR, CMD_END: begin
					if (cmd_s1 == CMD_CLEAR) begin
						len_d = '0;
						ovf_d = 1'b0;
					end
					ptr_d        = '0;
					bound_d      = 1'b1;
					prev_lower_d = 1'b0;
					prev_hit_d   = 1'b0;
					base_d       = '0;
					name_d       = '0;
					ones_d       = '0;
					tens_d       = '0;
				end
				CMD_APPEND: begin
					if (!is_space(char_s1)) begin
						if (len_q < LW'(QUERY_MAX)) begin
							wr_en = 1'b1;
							len_d = len_q + 1'b1;
						end else begin
							ovf_d = 1'b1;
						end
					end
				end
				CMD_CHAR: begin
					if (hit) begin
						base_d = base_q + BW'(pts);
						name_d = name_q + 1'b1;
						ptr_d  = ptr_q + 1'b1;
					end
					if (is_slash(char_s1)) begin
						name_d = '0;
					end
					prev_hit_d   = hit;
					bound_d      = is_sep(char_s1);
					prev_lower_d = is_lower(char_s1);
					// candidate length kept as tens and ones, saturating at 200
					if (tens_q < LEN_TENS_CAP) begin
						if (ones_q == LEN_ONES_LAST) begin
							ones_d = '0;
							tens_d = tens_q + 1'b1;
						end else begin
							ones_d = ones_q + 1'b1;
						end
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q        <= '0;
			ptr_q        <= '0;
			ovf_q        <= 1'b0;
			bound_q      <= 1'b1;
			prev_lower_q <= 1'b0;
			prev_hit_q   <= 1'b0;
			base_q       <= '0;
			name_q       <= '0;
			ones_q       <= '0;
			tens_q       <= '0;
			byp_q        <= 1'b0;
		end else begin
			len_q        <= len_d;
			ptr_q        <= ptr_d;
			ovf_q        <= ovf_d;
			bound_q      <= bound_d;
			prev_lower_q <= prev_lower_d;
			prev_hit_q   <= prev_hit_d;
			base_q       <= base_d;
			name_q       <= name_d;
			ones_q       <= ones_d;
			tens_q       <= tens_d;
			byp_q        <= wr_en && (len_q == ptr_d);
		end
	end

	// query store, read ahead at the next match position
	fss_ram #(
		.WIDTH($bits(char_t)),
		.DEPTH(QUERY_MAX)
	) u_store (
		.clk  (clk),
		.we   (wr_en),
		.waddr(len_q[AW-1:0]),
		.wdata(char_s1),
		.raddr(ptr_d[AW-1:0]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		byp_data_q <= char_s1;
	end

	// final score
	assign total   = TW'(base_q) + TW'(name_q) * TW'(BONUS_NAME);
	assign pen     = TW'(tens_q);
	assign net     = (total > pen) ? total - pen : '0;
	assign clamped = (net > TW'(SCORE_CEIL)) ? 10'(SCORE_CEIL) : net[9:0];

	always_comb begin
		if (len_q == '0) begin
			score_d = '0;
		end else if (ptr_q < len_q) begin
			score_d = -11'sd1;
		end else begin
			score_d = signed'({1'b0, clamped});
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance_s1 && cmd_s1 == CMD_END) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && cmd_s1 == CMD_END) begin
			res_score_q <= score_d;
			res_ovf_q   <= ovf_q;
		end
	end

	assign result.valid          = res_valid_q;
	assign result.score          = res_score_q;
	assign result.query_overflow = res_ovf_q;

`ifndef ASSERT_OFF
	// match position never passes the query length
	a_ptr_le_len: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_q <= len_q) else $error("match position beyond query length");

	// overflow only once the store is full
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> len_q == LW'(QUERY_MAX)) else $error("overflow with room left");

	// length counter stays within its saturation range
	a_len_cap: assert property (@(posedge clk) disable iff (!arst_n)
		tens_q <= LEN_TENS_CAP && ones_q <= LEN_ONES_LAST)
		else $error("candidate length counter out of range");

	// a new result only follows an end item leaving the input register
	a_res_from_end: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(advance_s1 && cmd_s1 == CMD_END))
		else $error("result without end item");
`endif
endmodule

`default_nettype wire

>>> tb/fuzzy_subsequence_scorer_tb.sv
// testbench for the fuzzy subsequence scorer: predicted scores checked against the result channel
`timescale 1ns / 1ps

module fuzzy_subsequence_scorer_tb;
	import fss_pkg::*;

	localparam int QUERY_DEPTH = QUERY_MAX_DEF;
	localparam int LEN_CAP     = 200;
	localparam int LEN_DIV     = 10;
	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 600;

	localparam logic [15:0] SEP_CHARS [8] = '{16'h002F, 16'h005C, 16'h005F, 16'h002D,
		16'h002E, 16'h0020, 16'h003A, 16'h203A};
	localparam logic [15:0] BLANK_CHARS [16] = '{16'h0009, 16'h000A, 16'h000B, 16'h000C,
		16'h000D, 16'h0020, 16'h0085, 16'h00A0, 16'h1680, 16'h2000, 16'h2005, 16'h200A,
		16'h2028, 16'h2029, 16'h202F, 16'h3000};

	typedef struct {
		logic signed [10:0] score;
		logic               overflow;
	} score_rec_t;

	logic clk;
	logic arst_n;

	fss_in_if  cand_if();
	fss_out_if res_if();

	fuzzy_subsequence_scorer #(.QUERY_MAX(QUERY_DEPTH)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cand(cand_if),
		.result(res_if)
	);

	// scorer state as predicted
	logic [15:0] q_store [QUERY_DEPTH];
	int unsigned q_len;
	int unsigned q_ptr;
	logic [15:0] prev_ch;
	bit          prev_hit;
	bit          at_first;
	int unsigned base_pts;
	int unsigned name_hits;
	int unsigned cand_len;
	bit          ovf_flag;

	score_rec_t pending_scores[$];

	int mismatch_count;
	int items_sent;
	int tx_idle_pct;
	int rx_idle_pct;
	int hold_left;
	int idle_cycles;

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// character classes, written independently of the design
	function automatic bit blank_char(input logic [15:0] c);
		return (c >= 16'h0009 && c <= 16'h000D) || c == 16'h0020 || c == 16'h0085 ||
			c == 16'h00A0 || c == 16'h1680 || (c >= 16'h2000 && c <= 16'h200A) ||
			c == 16'h2028 || c == 16'h2029 || c == 16'h202F || c == 16'h205F ||
			c == 16'h3000;
	endfunction

	function automatic bit lower_letter(input logic [15:0] c);
		return c >= "a" && c <= "z";
	endfunction

	function automatic bit upper_letter(input logic [15:0] c);
		return c >= "A" && c <= "Z";
	endfunction

	function automatic logic [15:0] to_lower(input logic [15:0] c);
		return upper_letter(c) ? c + 16'h0020 : c;
	endfunction

	function automatic bit word_break(input logic [15:0] c);
		bit hit;
		hit = 1'b0;
		foreach (SEP_CHARS[i])
			if (c == SEP_CHARS[i])
				hit = 1'b1;
		return hit;
	endfunction

	function automatic void restart_scan();
		q_ptr     = 0;
		prev_ch   = '0;
		prev_hit  = 1'b0;
		at_first  = 1'b1;
		base_pts  = 0;
		name_hits = 0;
		cand_len  = 0;
	endfunction

	// advance the predicted state by one accepted item
	function automatic void predict_item(input cmd_e cmd, input logic [15:0] ch);
		bit          hit;
		int unsigned pts;
		int unsigned total;
		int unsigned pen;
		int          s;
		score_rec_t  rec;
		case (cmd)
			CMD_CLEAR: begin
				q_len    = 0;
				ovf_flag = 1'b0;
				restart_scan();
			end
			CMD_APPEND: begin
				if (!blank_char(ch)) begin
					if (q_len < QUERY_DEPTH) begin
						q_store[q_len] = ch;
						q_len++;
					end else begin
						ovf_flag = 1'b1;
					end
				end
			end
			CMD_CHAR: begin
				hit = 1'b0;
				if (q_ptr < q_len && to_lower(ch) == to_lower(q_store[q_ptr])) begin
					pts = int'(PTS_MATCH);
					if (prev_hit)
						pts += BONUS_CONSEC;
					if (at_first || word_break(prev_ch) ||
						(lower_letter(prev_ch) && upper_letter(ch)))
						pts += BONUS_BOUNDARY;
					if (ch == q_store[q_ptr])
						pts += BONUS_CASE;
					base_pts += pts;
					name_hits++;
					q_ptr++;
					hit = 1'b1;
				end
				// a slash starts a new file name part
				if (ch == CHAR_SLASH || ch == CHAR_BSLASH)
					name_hits = 0;
				prev_hit = hit;
				prev_ch  = ch;
				at_first = 1'b0;
				if (cand_len < LEN_CAP)
					cand_len++;
			end
			CMD_END: begin
				if (q_len == 0) begin
					s = 0;
				end else if (q_ptr < q_len) begin
					s = -1;
				end else begin
					total = base_pts + BONUS_NAME * name_hits;
					pen   = cand_len / LEN_DIV;
					total = (total > pen) ? total - pen : 0;
					if (total > SCORE_CEIL)
						total = SCORE_CEIL;
					s = total;
				end
				rec.score    = s[10:0];
				rec.overflow = ovf_flag;
				pending_scores.push_back(rec);
				restart_scan();
			end
		endcase
	endfunction

	// send one item, with random idle cycles ahead of it
	task automatic send_item(input cmd_e cmd, input logic [15:0] ch);
		while ($urandom_range(99) < tx_idle_pct) begin
			cand_if.valid <= 1'b0;
			@(posedge clk);
		end
		cand_if.valid     <= 1'b1;
		cand_if.command   <= cmd;
		cand_if.char_code <= ch;
		do
			@(posedge clk);
		while (!cand_if.ready);
		predict_item(cmd, ch);
		items_sent++;
	endtask

	task automatic send_string(input cmd_e cmd, input string s);
		for (int i = 0; i < s.len(); i++)
			send_item(cmd, {8'h00, s[i]});
	endtask

	// random character pools
	function automatic logic [15:0] rand_letter();
		logic [15:0] c;
		c = 16'("a" + $urandom_range(4));
		return $urandom_range(1) ? c - 16'h0020 : c;
	endfunction

	function automatic logic [15:0] rand_query_char();
		int r;
		r = $urandom_range(99);
		if (r < 65)
			return rand_letter();
		else if (r < 75)
			return SEP_CHARS[$urandom_range(7)];
		else if (r < 85)
			return BLANK_CHARS[$urandom_range(15)];
		return 16'($urandom_range(16'hFFFF));
	endfunction

	function automatic logic [15:0] rand_filler();
		int r;
		r = $urandom_range(99);
		if (r < 40)
			return 16'("a" + $urandom_range(7)) -
				($urandom_range(1) ? 16'h0020 : 16'h0000);
		else if (r < 65)
			return SEP_CHARS[$urandom_range(7)];
		else if (r < 72)
			return BLANK_CHARS[$urandom_range(15)];
		return 16'($urandom_range(16'hFFFF));
	endfunction

	function automatic logic [15:0] vary_case(input logic [15:0] c);
		if ((lower_letter(c) || upper_letter(c)) && $urandom_range(1))
			return c ^ 16'h0020;
		return c;
	endfunction

	// one candidate: mostly a match with fillers, some random text, a few long ones
	task automatic run_candidate();
		logic [15:0] snap[$];
		int          kind;
		int          n;
		int          k;
		int          r;
		for (int i = 0; i < q_len; i++)
			snap.push_back(q_store[i]);
		kind = $urandom_range(99);
		if (kind < 80) begin
			foreach (snap[i]) begin
				n = ($urandom_range(9) < 7) ? 0 : $urandom_range(1, 3);
				repeat (n) send_item(CMD_CHAR, rand_filler());
				send_item(CMD_CHAR, vary_case(snap[i]));
				if ($urandom_range(99) < 2)
					send_item(CMD_APPEND, rand_query_char());
			end
			repeat ($urandom_range(3)) send_item(CMD_CHAR, rand_filler());
		end else if (kind < 95) begin
			repeat ($urandom_range(12)) send_item(CMD_CHAR, rand_filler());
		end else begin
			// long candidate, can run past the length cap
			n = $urandom_range(190, 260);
			k = 0;
			for (int i = 0; i < n; i++) begin
				if (k < snap.size() && $urandom_range(9) == 0) begin
					send_item(CMD_CHAR, vary_case(snap[k]));
					k++;
				end else begin
					send_item(CMD_CHAR, rand_filler());
				end
			end
			while (k < snap.size()) begin
				send_item(CMD_CHAR, snap[k]);
				k++;
			end
		end
		r = $urandom_range(99);
		if (r < 95)
			send_item(CMD_END, 16'($urandom_range(16'hFFFF)));
		else if (r < 98)
			send_item(CMD_CLEAR, 16'($urandom_range(16'hFFFF)));
	endtask

	// one query load followed by a few candidates
	task automatic run_session();
		int r;
		int n;
		if ($urandom_range(99) < 92)
			send_item(CMD_CLEAR, 16'($urandom_range(16'hFFFF)));
		r = $urandom_range(99);
		if (r < 10)
			n = 0;
		else if (r < 75)
			n = $urandom_range(1, 6);
		else if (r < 90)
			n = $urandom_range(7, 32);
		else
			n = $urandom_range(33, 40);
		repeat (n) send_item(CMD_APPEND, rand_query_char());
		repeat ($urandom_range(1, 4)) run_candidate();
	endtask

	// directed: empty query always scores zero
	task automatic test_empty_query();
		send_item(CMD_END, 16'hFFFF);
		send_item(CMD_CHAR, {8'h00, "a"});
		send_item(CMD_END, 16'h0000);
	endtask

	// directed: whitespace is skipped, extreme codes are stored and matched
	task automatic test_query_extremes();
		send_item(CMD_CLEAR, 16'h0000);
		send_item(CMD_APPEND, 16'h0009);
		send_item(CMD_APPEND, 16'h3000);
		send_item(CMD_APPEND, 16'h200A);
		send_item(CMD_APPEND, 16'h0085);
		send_item(CMD_APPEND, 16'h0008);
		send_item(CMD_APPEND, 16'hFFFF);
		send_item(CMD_APPEND, 16'h0000);
		send_item(CMD_CHAR, 16'h0008);
		send_item(CMD_CHAR, 16'hFFFF);
		send_item(CMD_CHAR, 16'h0000);
		send_item(CMD_END, 16'hFFFF);
	endtask

	// directed: slash, camel case and angle boundaries, file name count reset
	task automatic test_word_bonus();
		send_item(CMD_CLEAR, 16'hFFFF);
		send_string(CMD_APPEND, "abcd");
		send_string(CMD_CHAR, "/AxB");
		send_item(CMD_CHAR, CHAR_ANGLE);
		send_string(CMD_CHAR, "cd/");
		send_item(CMD_END, 16'h0000);
	endtask

	// directed: incomplete match, then an append in the middle of a candidate
	task automatic test_partial_and_late_append();
		send_string(CMD_CHAR, "ab");
		send_item(CMD_END, 16'h0000);
		send_string(CMD_CHAR, "abcd");
		send_item(CMD_APPEND, {8'h00, "e"});
		send_item(CMD_CHAR, {8'h00, "E"});
		send_item(CMD_END, 16'h0000);
	endtask

	// result side held off for a long stretch while short candidates keep coming
	task automatic test_result_backpressure();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		send_item(CMD_CLEAR, 16'h0000);
		send_string(CMD_APPEND, "ab");
		@(negedge clk);
		hold_left = HOLD_CYCLES;
		repeat (12) begin
			send_string(CMD_CHAR, "aB");
			send_item(CMD_END, 16'h0000);
		end
	endtask

	task automatic test_random_phase(input int tx_pct, input int rx_pct);
		int stop_at;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		stop_at = items_sent + PHASE_ITEMS;
		while (items_sent < stop_at)
			run_session();
	endtask

	// result side: ready with random stalls or a long hold-off
	initial begin
		res_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				res_if.ready <= 1'b0;
				hold_left--;
			end else begin
				res_if.ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// compare each result with the oldest predicted score
	initial begin
		score_rec_t want;
		forever begin
			@(posedge clk);
			if (arst_n && res_if.valid && res_if.ready) begin
				if (pending_scores.size() == 0) begin
					if (mismatch_count < 10)
						$display("unexpected result: score %0d overflow %0b",
							res_if.score, res_if.query_overflow);
					mismatch_count++;
				end else begin
					want = pending_scores.pop_front();
					if (res_if.score !== want.score ||
						res_if.query_overflow !== want.overflow) begin
						if (mismatch_count < 10)
							$display("mismatch: score exp %0d got %0d, overflow exp %0b got %0b",
								want.score, res_if.score, want.overflow,
								res_if.query_overflow);
						mismatch_count++;
					end
				end
			end
		end
	end

	// watchdog: too many cycles without any item moving
	initial begin
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((cand_if.valid && cand_if.ready) || (res_if.valid && res_if.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("tb: failure");
		$finish;
	end

	// test sequence
	initial begin
		mismatch_count    = 0;
		items_sent        = 0;
		hold_left         = 0;
		tx_idle_pct       = 25;
		rx_idle_pct       = 69;
		cand_if.valid     = 1'b0;
		cand_if.command   = CMD_CLEAR;
		cand_if.char_code = '0;
		q_len             = 0;
		ovf_flag          = 1'b0;
		restart_scan();
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_query();
		test_query_extremes();
		test_word_bonus();
		test_partial_and_late_append();
		test_result_backpressure();
		test_random_phase(25, 69);
		test_random_phase(69, 25);
		test_random_phase(0, 0);

		cand_if.valid <= 1'b0;
		while (pending_scores.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (mismatch_count == 0 && pending_scores.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

>>> files.f
rtl/core/fss_pkg.sv
rtl/core/fss_in_if.sv
rtl/core/fss_out_if.sv
rtl/core/fss_ram.sv
rtl/core/fuzzy_subsequence_scorer.sv
tb/fuzzy_subsequence_scorer_tb.sv
